[rtl/core/bipid_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bipid_pkg;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int DIFF_W   = SAMPLE_W + 2;
	localparam int GAIN_W   = 20;
	localparam int BAND_W   = 16;
	localparam int LIMIT_W  = 22;
	localparam int INTEG_W  = 24;
	localparam int DRIVE_W  = 32;

	// product and sum widths
	localparam int PROD_P_W = GAIN_W + ERR_W;
	localparam int PROD_I_W = GAIN_W + INTEG_W;
	localparam int PROD_D_W = GAIN_W + DIFF_W;
	localparam int ACC_W    = PROD_I_W + 2;
	localparam int FRAC_W   = 8;
	localparam int SHIFT_W  = ACC_W - FRAC_W;

	// apb port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;

	// register reset values
	localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST     = 20'sd25600;
	localparam logic signed [GAIN_W-1:0] GAIN_INTEGRAL_RST = 20'sd0;
	localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST    = 20'sd0;
	localparam logic [BAND_W-1:0]        BAND_RST          = 16'd5120;
	localparam logic [LIMIT_W-1:0]       LIMIT_RST         = 22'd384000;

	localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7fff_ffff;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		REG_GAIN_PROP     = 3'd0,
		REG_GAIN_INTEGRAL = 3'd1,
		REG_GAIN_DERIV    = 3'd2,
		REG_BAND          = 3'd3,
		REG_LIMIT         = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_prop;
		logic signed [GAIN_W-1:0] gain_integral;
		logic signed [GAIN_W-1:0] gain_deriv;
		logic [BAND_W-1:0]        integration_band;
		logic [LIMIT_W-1:0]       integrator_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] setpoint;
		logic signed [SAMPLE_W-1:0] measured;
		logic                       hold_integration;
	} sample_t;

	typedef struct packed {
		logic signed [PROD_P_W-1:0] prop;
		logic signed [PROD_I_W-1:0] integ;
		logic signed [PROD_D_W-1:0] deriv;
	} prod_t;

	typedef struct packed {
		logic signed [INTEG_W-1:0] integrator;
		logic signed [ERR_W-1:0]   prev_error;
		logic signed [ERR_W-1:0]   error;
	} law_status_t;

endpackage

`default_nettype wire

[rtl/core/bipid_sample_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bipid_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [bipid_pkg::SAMPLE_W-1:0] setpoint;
	logic signed [bipid_pkg::SAMPLE_W-1:0] measured;
	logic                                 hold_integration;

	modport source (output valid, output setpoint, output measured,
		output hold_integration, input ready);
	modport sink (input valid, input setpoint, input measured,
		input hold_integration, output ready);
endinterface

`default_nettype wire

[rtl/core/bipid_drive_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bipid_drive_if;
	logic                                valid;
	logic                                ready;
	logic signed [bipid_pkg::DRIVE_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

`default_nettype wire

[rtl/core/bipid_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module bipid_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [bipid_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [bipid_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [bipid_pkg::APB_DATA_W-1:0] prdata,
	output bipid_pkg::cfg_t                       cfg
);

	bipid_pkg::cfg_t      cfg_q;
	bipid_pkg::reg_idx_t  idx;
	logic                 wr;

	assign idx = bipid_pkg::reg_idx_t'(paddr[4:2]);
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop        <= bipid_pkg::GAIN_PROP_RST;
			cfg_q.gain_integral    <= bipid_pkg::GAIN_INTEGRAL_RST;
			cfg_q.gain_deriv       <= bipid_pkg::GAIN_DERIV_RST;
			cfg_q.integration_band <= bipid_pkg::BAND_RST;
			cfg_q.integrator_limit <= bipid_pkg::LIMIT_RST;
		end else if (wr) begin
			unique case (idx)
				bipid_pkg::REG_GAIN_PROP:
					cfg_q.gain_prop <= pwdata[bipid_pkg::GAIN_W-1:0];
				bipid_pkg::REG_GAIN_INTEGRAL:
					cfg_q.gain_integral <= pwdata[bipid_pkg::GAIN_W-1:0];
				bipid_pkg::REG_GAIN_DERIV:
					cfg_q.gain_deriv <= pwdata[bipid_pkg::GAIN_W-1:0];
				bipid_pkg::REG_BAND:
					cfg_q.integration_band <= pwdata[bipid_pkg::BAND_W-1:0];
				bipid_pkg::REG_LIMIT:
					cfg_q.integrator_limit <= pwdata[bipid_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// signed gains read back sign extended
	always_comb begin
		unique case (idx)
			bipid_pkg::REG_GAIN_PROP:
				prdata = bipid_pkg::APB_DATA_W'(cfg_q.gain_prop);
			bipid_pkg::REG_GAIN_INTEGRAL:
				prdata = bipid_pkg::APB_DATA_W'(cfg_q.gain_integral);
			bipid_pkg::REG_GAIN_DERIV:
				prdata = bipid_pkg::APB_DATA_W'(cfg_q.gain_deriv);
			bipid_pkg::REG_BAND:
				prdata = {{(bipid_pkg::APB_DATA_W-bipid_pkg::BAND_W){1'b0}},
					cfg_q.integration_band};
			bipid_pkg::REG_LIMIT:
				prdata = {{(bipid_pkg::APB_DATA_W-bipid_pkg::LIMIT_W){1'b0}},
					cfg_q.integrator_limit};
			default:
				prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/core/bipid_law.sv]
`timescale 1ns / 1ps
`default_nettype none

module bipid_law (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  bipid_pkg::cfg_t            cfg,
	input  bipid_pkg::sample_t         item,
	input  wire logic                  step,
	output bipid_pkg::prod_t           prod,
	output bipid_pkg::law_status_t     status
);

	localparam int SUM_W = bipid_pkg::INTEG_W + 1;

	logic signed [bipid_pkg::INTEG_W-1:0] integ_q;
	logic signed [bipid_pkg::ERR_W-1:0]   prev_err_q;
	logic signed [bipid_pkg::ERR_W-1:0]   err;
	logic        [bipid_pkg::ERR_W-1:0]   mag;
	logic signed [bipid_pkg::DIFF_W-1:0]  diff;
	logic signed [SUM_W-1:0]              sum;
	logic signed [SUM_W-1:0]              lim_pos;
	logic signed [SUM_W-1:0]              lim_neg;
	logic signed [SUM_W-1:0]              clamped;
	logic signed [bipid_pkg::INTEG_W-1:0] integ_d;
	logic                                 integ_en;
	bipid_pkg::prod_t                     prod_s2;

	assign err = bipid_pkg::ERR_W'(item.setpoint) - bipid_pkg::ERR_W'(item.measured);
	assign mag = err[bipid_pkg::ERR_W-1] ? bipid_pkg::ERR_W'(-err) : bipid_pkg::ERR_W'(err);

	// integrate only inside the band and when not held
	assign integ_en = !item.hold_integration &&
		(mag < {1'b0, cfg.integration_band});

	assign sum = SUM_W'(integ_q) + (integ_en ? SUM_W'(err) : SUM_W'(0));
	assign lim_pos = {{(SUM_W-bipid_pkg::LIMIT_W){1'b0}}, cfg.integrator_limit};
	assign lim_neg = -lim_pos;

	always_comb begin
		if (sum > lim_pos) begin
			clamped = lim_pos;
		end else if (sum < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = sum;
		end
	end

	assign integ_d = clamped[bipid_pkg::INTEG_W-1:0];
	assign diff = bipid_pkg::DIFF_W'(err) - bipid_pkg::DIFF_W'(prev_err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
		end else if (step) begin
			integ_q    <= integ_d;
			prev_err_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			prod_s2.prop  <= bipid_pkg::PROD_P_W'(cfg.gain_prop) *
				bipid_pkg::PROD_P_W'(err);
			prod_s2.integ <= bipid_pkg::PROD_I_W'(cfg.gain_integral) *
				bipid_pkg::PROD_I_W'(integ_d);
			prod_s2.deriv <= bipid_pkg::PROD_D_W'(cfg.gain_deriv) *
				bipid_pkg::PROD_D_W'(diff);
		end
	end

	assign prod              = prod_s2;
	assign status.integrator = integ_q;
	assign status.prev_error = prev_err_q;
	assign status.error      = err;

endmodule

`default_nettype wire

[rtl/core/bipid_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module bipid_out (
	input  wire logic                              clk,
	input  bipid_pkg::prod_t                       prod,
	input  wire logic                              load,
	output logic signed [bipid_pkg::DRIVE_W-1:0]   drive
);

	localparam int TOP_W = bipid_pkg::SHIFT_W - bipid_pkg::DRIVE_W + 1;

	logic signed [bipid_pkg::ACC_W-1:0]   acc;
	logic signed [bipid_pkg::SHIFT_W-1:0] sh;
	logic        [TOP_W-1:0]              top_bits;
	logic signed [bipid_pkg::DRIVE_W-1:0] sat;
	logic signed [bipid_pkg::DRIVE_W-1:0] drive_s3;

	assign acc = bipid_pkg::ACC_W'(prod.prop) + bipid_pkg::ACC_W'(prod.integ) +
		bipid_pkg::ACC_W'(prod.deriv);

	// floor division by 256
	assign sh = acc[bipid_pkg::ACC_W-1:bipid_pkg::FRAC_W];
	assign top_bits = sh[bipid_pkg::SHIFT_W-1:bipid_pkg::DRIVE_W-1];

	always_comb begin
		if ((&top_bits) || !(|top_bits)) begin
			sat = sh[bipid_pkg::DRIVE_W-1:0];
		end else if (sh[bipid_pkg::SHIFT_W-1]) begin
			sat = bipid_pkg::DRIVE_MIN;
		end else begin
			sat = bipid_pkg::DRIVE_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			drive_s3 <= sat;
		end
	end

	assign drive = drive_s3;

endmodule

`default_nettype wire

[rtl/core/banded_integral_pid.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   kind        width  contents
// sample    valid/ready 33     setpoint, measured, hold_integration
// command   valid/ready 32     drive
// apb       apb write   32     gains, integration band, integrator limit
//
// one item per cycle sustained while command.ready holds; drive valid once the item is in the sum/saturate register
// stages: input register, error/integrator/multiply register, sum/saturate register
// the integrator and previous error update as an item leaves the input register
// each stage advances when its successor is free, so bubbles absorb stalls
// reset clears valid bits, the integrator and the previous error, and loads the config registers' reset values
module banded_integral_pid (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	bipid_sample_if.sink                          sample,
	bipid_drive_if.source                         command,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [bipid_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [bipid_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [bipid_pkg::APB_DATA_W-1:0] prdata,
	output logic                                  pready
);

	bipid_pkg::cfg_t        cfg;
	bipid_pkg::sample_t     item_s1;
	bipid_pkg::prod_t       prod;
	bipid_pkg::law_status_t status;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic en1;
	logic en2;
	logic en3;
	logic step;

	logic signed [bipid_pkg::INTEG_W:0] integ_w;
	logic signed [bipid_pkg::INTEG_W:0] lim_w;

	assign pready = 1'b1;

	bipid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// stall chain: a stage loads when it is empty or its successor moves
	assign en3 = !valid_s3 || command.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign step = valid_s1 && en2;

	assign sample.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= sample.valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en1 && sample.valid) begin
			item_s1.setpoint         <= sample.setpoint;
			item_s1.measured         <= sample.measured;
			item_s1.hold_integration <= sample.hold_integration;
		end
	end

	// error, banded integration, clamp and the three gain products
	bipid_law u_law (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (step),
		.prod   (prod),
		.status (status)
	);

	// sum, scale back to q24.8 and saturate
	bipid_out u_out (
		.clk   (clk),
		.prod  (prod),
		.load  (en3 && valid_s2),
		.drive (command.drive)
	);

	assign command.valid = valid_s3;

	assign integ_w = (bipid_pkg::INTEG_W + 1)'(status.integrator);
	assign lim_w   = {3'b000, cfg.integrator_limit};

	// an empty output register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s3 |-> sample.ready)
		else $error("sample not ready while output register empty");

	// integrator stays within the limit in force at its update
	a_integ_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (integ_w <= $past(lim_w)) && (integ_w >= -$past(lim_w)))
		else $error("integrator outside clamp");

	// previous error takes the error of the item just stepped
	a_prev_error: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> status.prev_error == $past(status.error))
		else $error("previous error not updated");

	// no state update without an item in the input register
	a_step_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(status.integrator))
		else $error("integrator changed without an item");

endmodule

`default_nettype wire
